FILE: hw/rtl/smmat_pkg.sv
// Shared types and constants for the sensor min/max/average tracker.
package smmat_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PERIOD_W    = 24;
   localparam int STAMP_W     = 25;
   localparam int VALUE_W     = 17;
   localparam int NUM_CH      = 3;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_FULL_STATS    = 2'd0;
   localparam csr_index_type CSR_SAMPLE_PERIOD = 2'd1;
   localparam csr_index_type CSR_REPORT_PERIOD = 2'd2;

   typedef logic [1:0] channel_type;
   localparam channel_type CH_TEMP = 2'd0;
   localparam channel_type CH_VIS  = 2'd1;
   localparam channel_type CH_IR   = 2'd2;

   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 24'd3600;
   localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RESET = 24'd86400;

   localparam logic signed [7:0]        TEMP_HIGH_RESET  = 8'sh80;
   localparam logic signed [7:0]        TEMP_LOW_RESET   = 8'sh7F;
   localparam logic [15:0]              LIGHT_TOP        = 16'hFFFF;
   localparam logic [15:0]              LIGHT_HIGH_RESET = 16'h0000;
   localparam logic signed [STAMP_W-1:0] STAMP_NONE      = 25'h1FFFFFF;

   typedef struct packed {
      logic signed [7:0]         temp;
      logic [15:0]               vis;
      logic [15:0]               ir;
      logic signed [STAMP_W-1:0] stamp;
      logic                      report;
      logic                      full;
   } tick_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] cur;
      logic signed [VALUE_W-1:0] avg;
      logic signed [VALUE_W-1:0] max;
      logic signed [STAMP_W-1:0] max_time;
      logic signed [VALUE_W-1:0] min;
      logic signed [STAMP_W-1:0] min_time;
   } chan_rep_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hw/rtl/smmat_front.sv
// Front end: accepts ticks, runs the report countdown and classifies each tick.
module smmat_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_func,
   input  logic signed [7:0]                 req_temp_sample,
   input  logic [15:0]                       req_visible_sample,
   input  logic [15:0]                       req_infrared_sample,
   input  logic                              full_stats,
   input  logic [smmat_pkg::PERIOD_W-1:0]    sample_period,
   input  logic [smmat_pkg::PERIOD_W-1:0]    report_period,
   input  smmat_pkg::queue_status_type       q_status,
   output logic                              tick_push,
   output smmat_pkg::tick_type               tick
);

   logic signed [smmat_pkg::STAMP_W-1:0] countdown_ff;
   logic signed [smmat_pkg::STAMP_W-1:0] countdown_in;
   logic signed [smmat_pkg::STAMP_W-1:0] cd_next;
   logic signed [smmat_pkg::STAMP_W-1:0] reload;
   logic                                 accept;
   logic                                 report;

   assign req_full  = q_status.full;
   assign accept    = req_push && !q_status.full;
   assign reload    = $signed({1'b0, report_period});
   assign cd_next   = countdown_ff - $signed({1'b0, sample_period});
   assign report    = cd_next[smmat_pkg::STAMP_W-1] || (cd_next == '0);
   assign tick_push = accept && !req_func;

   assign tick.temp   = req_temp_sample;
   assign tick.vis    = req_visible_sample;
   assign tick.ir     = req_infrared_sample;
   assign tick.stamp  = cd_next;
   assign tick.report = report;
   assign tick.full   = full_stats;

   always_comb begin
      countdown_in = countdown_ff;
      if (accept) begin
         if (req_func || report) begin
            countdown_in = reload;
         end else begin
            countdown_in = cd_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= $signed({1'b0, smmat_pkg::REPORT_PERIOD_RESET});
      end else begin
         countdown_ff <= countdown_in;
      end
   end

endmodule

FILE: hw/rtl/smmat_queue.sv
// Short tick queue between the front and back ends.
module smmat_queue #(
   parameter int DEPTH = smmat_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  smmat_pkg::tick_type         wdata,
   input  logic                        pop,
   output smmat_pkg::tick_type         rdata,
   output smmat_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   smmat_pkg::tick_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push;
   logic                do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/smmat_back.sv
// Back end: updates the trackers, snapshots reports and serves the three report transfers.
module smmat_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  smmat_pkg::tick_type                      head,
   input  smmat_pkg::queue_status_type              q_status,
   output logic                                     q_pop,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic [1:0]                               rsp_channel,
   output logic signed [smmat_pkg::VALUE_W-1:0]     rsp_current,
   output logic signed [smmat_pkg::VALUE_W-1:0]     rsp_average,
   output logic signed [smmat_pkg::VALUE_W-1:0]     rsp_maximum,
   output logic signed [smmat_pkg::STAMP_W-1:0]     rsp_max_time,
   output logic signed [smmat_pkg::VALUE_W-1:0]     rsp_minimum,
   output logic signed [smmat_pkg::STAMP_W-1:0]     rsp_min_time,
   output logic                                     rsp_last
);

   localparam int SW = smmat_pkg::STAMP_W;

   logic signed [7:0]    temp_now_ff, temp_mean_ff, temp_high_ff, temp_low_ff;
   logic signed [SW-1:0] temp_hi_t_ff, temp_lo_t_ff;
   logic signed [7:0]    temp_now_in, temp_mean_in, temp_high_in, temp_low_in;
   logic signed [SW-1:0] temp_hi_t_in, temp_lo_t_in;

   logic [15:0]          light_now_ff [2];
   logic [15:0]          light_mean_ff [2];
   logic [15:0]          light_high_ff [2];
   logic [15:0]          light_low_ff [2];
   logic signed [SW-1:0] light_hi_t_ff [2];
   logic signed [SW-1:0] light_lo_t_ff [2];
   logic [15:0]          light_now_in [2];
   logic [15:0]          light_mean_in [2];
   logic [15:0]          light_high_in [2];
   logic [15:0]          light_low_in [2];
   logic signed [SW-1:0] light_hi_t_in [2];
   logic signed [SW-1:0] light_lo_t_in [2];

   smmat_pkg::chan_rep_type rep_ff [smmat_pkg::NUM_CH];
   smmat_pkg::chan_rep_type rep_in [smmat_pkg::NUM_CH];
   logic                    rep_valid_ff;
   smmat_pkg::channel_type  beat_ff;

   logic signed [8:0]    tsum;
   logic signed [8:0]    tsum_adj;
   logic [15:0]          sample [2];
   logic [16:0]          lsum [2];
   logic                 out_take;
   logic                 out_done;
   logic                 load_ok;

   assign sample[0] = head.vis;
   assign sample[1] = head.ir;

   assign out_take  = rsp_pop && rep_valid_ff;
   assign out_done  = out_take && (beat_ff == smmat_pkg::CH_IR);
   assign load_ok   = !rep_valid_ff || out_done;
   assign q_pop     = !q_status.empty && (!head.report || load_ok);

   assign tsum     = {head.temp[7], head.temp} + {temp_now_ff[7], temp_now_ff};
   assign tsum_adj = tsum + {8'd0, tsum[8] & tsum[0]};

   always_comb begin
      temp_now_in  = head.temp;
      temp_mean_in = temp_mean_ff;
      temp_high_in = temp_high_ff;
      temp_low_in  = temp_low_ff;
      temp_hi_t_in = temp_hi_t_ff;
      temp_lo_t_in = temp_lo_t_ff;
      if (head.full) begin
         temp_mean_in = tsum_adj[8:1];
         if (head.temp > temp_high_ff) begin
            temp_high_in = head.temp;
            temp_hi_t_in = head.stamp;
         end
         if (head.temp < temp_low_ff) begin
            temp_low_in  = head.temp;
            temp_lo_t_in = head.stamp;
         end
      end
   end

   for (genvar i = 0; i < 2; i++) begin : g_light
      assign lsum[i] = {1'b0, sample[i]} + {1'b0, light_now_ff[i]};
      always_comb begin
         light_now_in[i]  = sample[i];
         light_mean_in[i] = light_mean_ff[i];
         light_high_in[i] = light_high_ff[i];
         light_low_in[i]  = light_low_ff[i];
         light_hi_t_in[i] = light_hi_t_ff[i];
         light_lo_t_in[i] = light_lo_t_ff[i];
         if (head.full) begin
            light_mean_in[i] = lsum[i][16:1];
            if (sample[i] > light_high_ff[i]) begin
               light_high_in[i] = sample[i];
               light_hi_t_in[i] = head.stamp;
            end
            if (sample[i] < light_low_ff[i]) begin
               light_low_in[i]  = sample[i];
               light_lo_t_in[i] = head.stamp;
            end
         end
      end
   end

   always_comb begin
      rep_in[0].cur      = {{9{temp_now_in[7]}}, temp_now_in};
      rep_in[0].avg      = {{9{temp_mean_in[7]}}, temp_mean_in};
      rep_in[0].max      = {{9{temp_high_in[7]}}, temp_high_in};
      rep_in[0].max_time = temp_hi_t_in;
      rep_in[0].min      = {{9{temp_low_in[7]}}, temp_low_in};
      rep_in[0].min_time = temp_lo_t_in;
      for (int i = 0; i < 2; i++) begin
         rep_in[i+1].cur      = {1'b0, light_now_in[i]};
         rep_in[i+1].avg      = {1'b0, light_mean_in[i]};
         rep_in[i+1].max      = {1'b0, light_high_in[i]};
         rep_in[i+1].max_time = light_hi_t_in[i];
         rep_in[i+1].min      = {1'b0, light_low_in[i]};
         rep_in[i+1].min_time = light_lo_t_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (q_pop && head.report)) begin
         temp_now_ff  <= smmat_pkg::TEMP_LOW_RESET;
         temp_mean_ff <= smmat_pkg::TEMP_LOW_RESET;
         temp_high_ff <= smmat_pkg::TEMP_HIGH_RESET;
         temp_low_ff  <= smmat_pkg::TEMP_LOW_RESET;
         temp_hi_t_ff <= smmat_pkg::STAMP_NONE;
         temp_lo_t_ff <= smmat_pkg::STAMP_NONE;
         for (int i = 0; i < 2; i++) begin
            light_now_ff[i]  <= smmat_pkg::LIGHT_TOP;
            light_mean_ff[i] <= smmat_pkg::LIGHT_TOP;
            light_high_ff[i] <= smmat_pkg::LIGHT_HIGH_RESET;
            light_low_ff[i]  <= smmat_pkg::LIGHT_TOP;
            light_hi_t_ff[i] <= smmat_pkg::STAMP_NONE;
            light_lo_t_ff[i] <= smmat_pkg::STAMP_NONE;
         end
      end else if (q_pop) begin
         temp_now_ff  <= temp_now_in;
         temp_mean_ff <= temp_mean_in;
         temp_high_ff <= temp_high_in;
         temp_low_ff  <= temp_low_in;
         temp_hi_t_ff <= temp_hi_t_in;
         temp_lo_t_ff <= temp_lo_t_in;
         for (int i = 0; i < 2; i++) begin
            light_now_ff[i]  <= light_now_in[i];
            light_mean_ff[i] <= light_mean_in[i];
            light_high_ff[i] <= light_high_in[i];
            light_low_ff[i]  <= light_low_in[i];
            light_hi_t_ff[i] <= light_hi_t_in[i];
            light_lo_t_ff[i] <= light_lo_t_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && head.report) begin
         for (int i = 0; i < smmat_pkg::NUM_CH; i++) begin
            rep_ff[i] <= rep_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_valid_ff <= 1'b0;
         beat_ff      <= smmat_pkg::CH_TEMP;
      end else if (q_pop && head.report) begin
         rep_valid_ff <= 1'b1;
         beat_ff      <= smmat_pkg::CH_TEMP;
      end else if (out_done) begin
         rep_valid_ff <= 1'b0;
         beat_ff      <= smmat_pkg::CH_TEMP;
      end else if (out_take) begin
         beat_ff      <= beat_ff + 1'b1;
      end
   end

   assign rsp_empty    = !rep_valid_ff;
   assign rsp_channel  = beat_ff;
   assign rsp_current  = rep_ff[beat_ff].cur;
   assign rsp_average  = rep_ff[beat_ff].avg;
   assign rsp_maximum  = rep_ff[beat_ff].max;
   assign rsp_max_time = rep_ff[beat_ff].max_time;
   assign rsp_minimum  = rep_ff[beat_ff].min;
   assign rsp_min_time = rep_ff[beat_ff].min_time;
   assign rsp_last     = (beat_ff == smmat_pkg::CH_IR);

endmodule

FILE: hw/rtl/sensor_min_max_avg_tracker.sv
// Top level of the sensor min/max/average tracker.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_push / req_full | func, temp, visible, infrared samples
//   rsp     | out       | rsp_pop / rsp_empty | channel, current, average, extremes, stamps
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One tick is taken per cycle while the tick queue has room; the front end does the
// countdown subtract and report decision in the accepting cycle.
// A report tick yields three result transfers from a snapshot register, one per cycle while
// rsp_pop is held; a report tick waits until the last transfer of the previous one.
// Ordinary ticks keep updating the trackers while a report is being drained.
// Synchronous reset restores the registers, the countdown and all trackers.
module sensor_min_max_avg_tracker #(
   parameter int QUEUE_DEPTH = smmat_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_func,
   input  logic signed [7:0]                    req_temp_sample,
   input  logic [15:0]                          req_visible_sample,
   input  logic [15:0]                          req_infrared_sample,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [1:0]                           rsp_channel,
   output logic signed [smmat_pkg::VALUE_W-1:0] rsp_current,
   output logic signed [smmat_pkg::VALUE_W-1:0] rsp_average,
   output logic signed [smmat_pkg::VALUE_W-1:0] rsp_maximum,
   output logic signed [smmat_pkg::STAMP_W-1:0] rsp_max_time,
   output logic signed [smmat_pkg::VALUE_W-1:0] rsp_minimum,
   output logic signed [smmat_pkg::STAMP_W-1:0] rsp_min_time,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [smmat_pkg::PERIOD_W-1:0]       csr_data
);

   logic                                full_stats_ff;
   logic [smmat_pkg::PERIOD_W-1:0]      sample_period_ff;
   logic [smmat_pkg::PERIOD_W-1:0]      report_period_ff;
   logic                                csr_write;
   logic                                tick_push;
   logic                                q_pop;
   smmat_pkg::tick_type                 tick;
   smmat_pkg::tick_type                 head;
   smmat_pkg::queue_status_type         q_status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_stats_ff    <= 1'b1;
         sample_period_ff <= smmat_pkg::SAMPLE_PERIOD_RESET;
         report_period_ff <= smmat_pkg::REPORT_PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            smmat_pkg::CSR_FULL_STATS:    full_stats_ff    <= csr_data[0];
            smmat_pkg::CSR_SAMPLE_PERIOD: sample_period_ff <= csr_data;
            smmat_pkg::CSR_REPORT_PERIOD: report_period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   smmat_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_func            (req_func),
      .req_temp_sample     (req_temp_sample),
      .req_visible_sample  (req_visible_sample),
      .req_infrared_sample (req_infrared_sample),
      .full_stats          (full_stats_ff),
      .sample_period       (sample_period_ff),
      .report_period       (report_period_ff),
      .q_status            (q_status),
      .tick_push           (tick_push),
      .tick                (tick)
   );

   smmat_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (tick_push),
      .wdata  (tick),
      .pop    (q_pop),
      .rdata  (head),
      .status (q_status)
   );

   smmat_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_channel  (rsp_channel),
      .rsp_current  (rsp_current),
      .rsp_average  (rsp_average),
      .rsp_maximum  (rsp_maximum),
      .rsp_max_time (rsp_max_time),
      .rsp_minimum  (rsp_minimum),
      .rsp_min_time (rsp_min_time),
      .rsp_last     (rsp_last)
   );

   a_last_is_ir: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last == (rsp_channel == smmat_pkg::CH_IR)))
      else $error("last flag and channel disagree");

   a_beat_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last) |=>
         (!rsp_empty && (rsp_channel == 2'($past(rsp_channel) + 2'd1))))
      else $error("report transfers out of order");

   a_new_report_starts: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_last) |=>
         (rsp_empty || (rsp_channel == smmat_pkg::CH_TEMP)))
      else $error("report does not start with temperature");

   a_full_blocks_pop: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !q_pop) |=> q_status.full)
      else $error("tick queue lost an entry");

endmodule

FILE: tb/sv/sensor_min_max_avg_tracker_checker.sv
// Tick codes and the checker that predicts and compares the tracker's channel reports.
`timescale 1ns / 1ps

package sensor_tracker_tb_pkg;
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;
endpackage

module sensor_min_max_avg_tracker_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  logic                                 req_func,
   input  logic signed [7:0]                    req_temp_sample,
   input  logic [15:0]                          req_visible_sample,
   input  logic [15:0]                          req_infrared_sample,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  logic [1:0]                           rsp_channel,
   input  logic signed [smmat_pkg::VALUE_W-1:0] rsp_current,
   input  logic signed [smmat_pkg::VALUE_W-1:0] rsp_average,
   input  logic signed [smmat_pkg::VALUE_W-1:0] rsp_maximum,
   input  logic signed [smmat_pkg::STAMP_W-1:0] rsp_max_time,
   input  logic signed [smmat_pkg::VALUE_W-1:0] rsp_minimum,
   input  logic signed [smmat_pkg::STAMP_W-1:0] rsp_min_time,
   input  logic                                 rsp_last,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [smmat_pkg::PERIOD_W-1:0]       csr_data,
   output int                                   fail_count,
   output int                                   reports_due
);

   typedef struct {
      smmat_pkg::channel_type  chan;
      smmat_pkg::chan_rep_type rep;
      logic                    last;
   } channel_report_type;

   channel_report_type due_reports[$];

   logic                                 full_mode;
   logic [smmat_pkg::PERIOD_W-1:0]       sample_len;
   logic [smmat_pkg::PERIOD_W-1:0]       report_len;
   logic signed [smmat_pkg::STAMP_W-1:0] countdown;

   logic signed [7:0]                    temp_now, temp_mean, temp_high, temp_low;
   logic signed [smmat_pkg::STAMP_W-1:0] temp_high_at, temp_low_at;
   logic [15:0]                          light_now[2], light_mean[2];
   logic [15:0]                          light_high[2], light_low[2];
   logic signed [smmat_pkg::STAMP_W-1:0] light_high_at[2], light_low_at[2];

   initial begin
      fail_count  = 0;
      reports_due = 0;
   end

   task automatic report_fault(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_fault($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic void clear_trackers();
      temp_now     = smmat_pkg::TEMP_LOW_RESET;
      temp_mean    = smmat_pkg::TEMP_LOW_RESET;
      temp_high    = smmat_pkg::TEMP_HIGH_RESET;
      temp_low     = smmat_pkg::TEMP_LOW_RESET;
      temp_high_at = smmat_pkg::STAMP_NONE;
      temp_low_at  = smmat_pkg::STAMP_NONE;
      for (int i = 0; i < 2; i++) begin
         light_now[i]     = smmat_pkg::LIGHT_TOP;
         light_mean[i]    = smmat_pkg::LIGHT_TOP;
         light_high[i]    = smmat_pkg::LIGHT_HIGH_RESET;
         light_low[i]     = smmat_pkg::LIGHT_TOP;
         light_high_at[i] = smmat_pkg::STAMP_NONE;
         light_low_at[i]  = smmat_pkg::STAMP_NONE;
      end
   endfunction

   function automatic void queue_report(
      input smmat_pkg::channel_type               chan,
      input logic signed [smmat_pkg::VALUE_W-1:0] cur,
      input logic signed [smmat_pkg::VALUE_W-1:0] avg,
      input logic signed [smmat_pkg::VALUE_W-1:0] hi,
      input logic signed [smmat_pkg::STAMP_W-1:0] hi_at,
      input logic signed [smmat_pkg::VALUE_W-1:0] lo,
      input logic signed [smmat_pkg::STAMP_W-1:0] lo_at,
      input logic                                 last
   );
      channel_report_type r;
      r.chan         = chan;
      r.rep.cur      = cur;
      r.rep.avg      = avg;
      r.rep.max      = hi;
      r.rep.max_time = hi_at;
      r.rep.min      = lo;
      r.rep.min_time = lo_at;
      r.last         = last;
      due_reports.push_back(r);
   endfunction

   function automatic void track_sample(
      input logic              func,
      input logic signed [7:0] t,
      input logic [15:0]       vis,
      input logic [15:0]       ir
   );
      logic [15:0]       s[2];
      logic signed [7:0] prev_t;
      logic [15:0]       prev_l;
      logic [16:0]       sum_l;
      if (func == sensor_tracker_tb_pkg::FUNC_RESTART) begin
         countdown = $signed({1'b0, report_len});
         return;
      end
      s[0] = vis;
      s[1] = ir;
      countdown = countdown - $signed({1'b0, sample_len});
      if (full_mode) begin
         prev_t    = temp_now;
         temp_now  = t;
         // truncates toward zero
         temp_mean = 8'((int'(t) + int'(prev_t)) / 2);
         if (t > temp_high) begin
            temp_high    = t;
            temp_high_at = countdown;
         end
         if (t < temp_low) begin
            temp_low    = t;
            temp_low_at = countdown;
         end
         for (int i = 0; i < 2; i++) begin
            prev_l        = light_now[i];
            light_now[i]  = s[i];
            sum_l         = {1'b0, s[i]} + {1'b0, prev_l};
            light_mean[i] = sum_l[16:1];
            if (s[i] > light_high[i]) begin
               light_high[i]    = s[i];
               light_high_at[i] = countdown;
            end
            if (s[i] < light_low[i]) begin
               light_low[i]    = s[i];
               light_low_at[i] = countdown;
            end
         end
      end else begin
         temp_now     = t;
         light_now[0] = s[0];
         light_now[1] = s[1];
      end
      if (countdown > 0) begin
         return;
      end
      queue_report(smmat_pkg::CH_TEMP, temp_now, temp_mean, temp_high, temp_high_at,
                   temp_low, temp_low_at, 1'b0);
      queue_report(smmat_pkg::CH_VIS, {1'b0, light_now[0]}, {1'b0, light_mean[0]},
                   {1'b0, light_high[0]}, light_high_at[0],
                   {1'b0, light_low[0]}, light_low_at[0], 1'b0);
      queue_report(smmat_pkg::CH_IR, {1'b0, light_now[1]}, {1'b0, light_mean[1]},
                   {1'b0, light_high[1]}, light_high_at[1],
                   {1'b0, light_low[1]}, light_low_at[1], 1'b1);
      clear_trackers();
      countdown = $signed({1'b0, report_len});
   endfunction

   always @(posedge clock) begin
      channel_report_type want;
      if (reset) begin
         full_mode  = 1'b1;
         sample_len = smmat_pkg::SAMPLE_PERIOD_RESET;
         report_len = smmat_pkg::REPORT_PERIOD_RESET;
         countdown  = $signed({1'b0, smmat_pkg::REPORT_PERIOD_RESET});
         clear_trackers();
         due_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               smmat_pkg::CSR_FULL_STATS:    full_mode  = csr_data[0];
               smmat_pkg::CSR_SAMPLE_PERIOD: sample_len = csr_data;
               smmat_pkg::CSR_REPORT_PERIOD: report_len = csr_data;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (due_reports.size() == 0) begin
               report_fault($sformatf("report transfer on channel %0d with none expected",
                                      rsp_channel));
            end else begin
               want = due_reports.pop_front();
               compare_field("channel", rsp_channel, want.chan);
               compare_field("current", rsp_current, want.rep.cur);
               compare_field("average", rsp_average, want.rep.avg);
               compare_field("maximum", rsp_maximum, want.rep.max);
               compare_field("max_time", rsp_max_time, want.rep.max_time);
               compare_field("minimum", rsp_minimum, want.rep.min);
               compare_field("min_time", rsp_min_time, want.rep.min_time);
               compare_field("last", rsp_last, want.last);
            end
         end
         if (req_push && !req_full) begin
            track_sample(req_func, req_temp_sample, req_visible_sample, req_infrared_sample);
         end
      end
      reports_due = due_reports.size();
   end

endmodule

FILE: tb/sv/sensor_min_max_avg_tracker_tb.sv
// Top of the sensor tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sensor_min_max_avg_tracker_tb;

   localparam int CLK_PERIOD    = 12;
   localparam int SETTLE_CYCLES = 4 * smmat_pkg::QUEUE_DEPTH + 16;
   localparam int MAX_CYCLES    = 400000;
   localparam int PERIOD_TOP    = 24'hFFFFFF;

   logic                                 clock               = 1'b0;
   logic                                 reset               = 1'b1;
   logic                                 req_push            = 1'b0;
   logic                                 req_full;
   logic                                 req_func            = sensor_tracker_tb_pkg::FUNC_TICK;
   logic signed [7:0]                    req_temp_sample     = '0;
   logic [15:0]                          req_visible_sample  = '0;
   logic [15:0]                          req_infrared_sample = '0;
   logic                                 rsp_empty;
   logic                                 rsp_pop             = 1'b0;
   logic [1:0]                           rsp_channel;
   logic signed [smmat_pkg::VALUE_W-1:0] rsp_current, rsp_average, rsp_maximum, rsp_minimum;
   logic signed [smmat_pkg::STAMP_W-1:0] rsp_max_time, rsp_min_time;
   logic                                 rsp_last;
   logic                                 csr_valid           = 1'b0;
   logic                                 csr_ready;
   smmat_pkg::csr_index_type             csr_index           = smmat_pkg::CSR_FULL_STATS;
   logic [smmat_pkg::PERIOD_W-1:0]       csr_data            = '0;

   int                                   fail_count;
   int                                   reports_due;
   int                                   pop_cycle           = 0;
   int                                   stall_left          = 0;

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   sensor_min_max_avg_tracker i_dut (.*);

   sensor_min_max_avg_tracker_checker i_checker (.*);

   // receiver: free-running, random and long-stall stretches in turn
   always @(negedge clock) begin
      pop_cycle <= pop_cycle + 1;
      if (stall_left > 0) begin
         rsp_pop    <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         unique case ((pop_cycle / 64) % 4)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= ($urandom_range(0, 1) == 1);
            2: begin
               if ($urandom_range(0, 5) == 0) begin
                  rsp_pop    <= 1'b0;
                  stall_left <= $urandom_range(1, 24);
               end else begin
                  rsp_pop <= 1'b1;
               end
            end
            default: rsp_pop <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic send_item(input logic func, input logic signed [7:0] t,
                            input logic [15:0] vis, input logic [15:0] ir);
      @(negedge clock);
      req_push            <= 1'b1;
      req_func            <= func;
      req_temp_sample     <= t;
      req_visible_sample  <= vis;
      req_infrared_sample <= ir;
      do @(posedge clock); while (req_full);
   endtask

   task automatic pause(input int cycles);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input smmat_pkg::csr_index_type idx,
                            input logic [smmat_pkg::PERIOD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_light();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(input logic full, input int sp, input int rp, input int count);
      int                burst_left;
      logic              steady;
      logic              func;
      logic signed [7:0] t;
      burst_left = 0;
      steady     = ($urandom_range(0, 3) == 0);
      wait_for_drain();
      write_csr(smmat_pkg::CSR_FULL_STATS, {23'd0, full});
      write_csr(smmat_pkg::CSR_SAMPLE_PERIOD, sp[smmat_pkg::PERIOD_W-1:0]);
      write_csr(smmat_pkg::CSR_REPORT_PERIOD, rp[smmat_pkg::PERIOD_W-1:0]);
      for (int k = 0; k < count; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!steady && $urandom_range(0, 2) != 0) begin
               pause($urandom_range(1, 6));
            end
         end
         burst_left--;
         func = ($urandom_range(0, 11) == 0) ? sensor_tracker_tb_pkg::FUNC_RESTART
                                              : sensor_tracker_tb_pkg::FUNC_TICK;
         case ($urandom_range(0, 5))
            0:       t = -8'sd128;
            1:       t = 8'sd127;
            2:       t = 8'($urandom_range(0, 6)) - 8'sd3;
            default: t = 8'($urandom);
         endcase
         send_item(func, t, rand_light(), rand_light());
      end
   endtask

   initial begin
      int rp;
      int sp;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: 24 ticks of 3600 bring the countdown exactly to zero
      send_item(sensor_tracker_tb_pkg::FUNC_RESTART, 8'sd5, 16'd7, 16'd9);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 0, 100, 200);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 127, 16'hFFFF, 16'hFFFF);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 127, 16'hFFFF, 16'hFFFF);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -128, 0, 0);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -128, 0, 0);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -3, 1000, 1001);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 0, 1, 2);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -1, 16'hFFFF, 0);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 1, 0, 16'hFFFF);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -2, 16'h8000, 16'h7FFF);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 126, 16'h7FFF, 16'h8000);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -127, 16'h5555, 16'hAAAA);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 85, 16'hAAAA, 16'h5555);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -86, 3, 16'hFFFE);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 5, 16'hFFFE, 1);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -5, 2, 3);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 64, 16'h0F0F, 16'hF0F0);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -65, 16'hF0F0, 16'h0F0F);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 3, 12345, 54321);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -4, 54321, 12345);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 127, 0, 16'hFFFF);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -128, 16'hFFFF, 0);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, 7, 40000, 20000);
      send_item(sensor_tracker_tb_pkg::FUNC_TICK, -7, 20000, 40000);

      run_phase(1'b1, PERIOD_TOP, 1, 50);
      run_phase(1'b0, 5, 20, 50);
      run_phase(1'b1, 7, 30, 60);
      run_phase(1'b1, 1, PERIOD_TOP, 20);
      run_phase(1'b0, PERIOD_TOP, PERIOD_TOP, 40);
      for (int p = 0; p < 4; p++) begin
         rp = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 64)
                                           : $urandom_range(1, PERIOD_TOP);
         sp = rp / $urandom_range(1, 6) + 1;
         if (sp > PERIOD_TOP) begin
            sp = PERIOD_TOP;
         end
         run_phase(1'($urandom_range(0, 1)), sp, rp, 60);
      end

      wait_for_drain();
      if (fail_count == 0 && reports_due == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * MAX_CYCLES);
      $display("Test completed with failures");
      $finish;
   end

endmodule
